// ===== rtl/rcst_pkg.sv =====
package rcst_pkg;

  localparam int NUM_STREAMS = 64;
  localparam int SID_W = $clog2(NUM_STREAMS);

  localparam logic [16:0] SID_LIMIT = 17'(NUM_STREAMS);
  localparam logic [16:0] SID_FIRST = 17'd2;
  localparam logic [16:0] MAX_CHUNK_RESET = 17'd128;
  localparam logic [23:0] TIME_ESCAPE = 24'hffffff;
  localparam logic [31:0] TIME_UNSET = 32'hffffffff;

  localparam logic [1:0] FMT_FULL = 2'd0;
  localparam logic [1:0] FMT_NO_STREAM = 2'd1;
  localparam logic [1:0] FMT_DELTA = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RESERVED  = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NO_HEADER = 3'd3,
    ST_NO_TIME   = 3'd4
  } status_t;

  typedef logic [SID_W-1:0] addr_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [23:0] time_val;
    logic [31:0] ext_val;
    logic [23:0] len;
    logic [7:0]  typ;
    logic [31:0] strm;
  } hdr_t;

  typedef struct packed {
    hdr_t        hdr;
    logic [23:0] count;
  } entry_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    entry_t data;
  } wr_req_t;

  typedef struct packed {
    logic [16:0] chunk_stream;
    logic [1:0]  header_format;
    logic [23:0] time_field;
    logic [31:0] extended_time;
    logic [23:0] message_length;
    logic [7:0]  message_type;
    logic [31:0] message_stream;
    logic [16:0] payload_bytes;
  } chunk_t;

  typedef struct packed {
    status_t     status;
    logic        message_done;
    logic [23:0] resolved_length;
    logic [7:0]  resolved_type;
    logic [31:0] resolved_stream;
    logic [31:0] message_time;
    logic [16:0] bytes_taken;
    logic [16:0] bytes_left;
  } res_t;

endpackage

// ===== rtl/rcst_ifs.sv =====
interface rcst_chunk_if (
  input logic clk
);
  logic        valid;
  logic        ready;
  logic [16:0] chunk_stream;
  logic [1:0]  header_format;
  logic [23:0] time_field;
  logic [31:0] extended_time;
  logic [23:0] message_length;
  logic [7:0]  message_type;
  logic [31:0] message_stream;
  logic [16:0] payload_bytes;

  modport source (
    input  clk, ready,
    output valid, chunk_stream, header_format, time_field, extended_time,
           message_length, message_type, message_stream, payload_bytes
  );
  modport sink (
    input  clk, valid, chunk_stream, header_format, time_field, extended_time,
           message_length, message_type, message_stream, payload_bytes,
    output ready
  );
endinterface

interface rcst_result_if (
  input logic clk
);
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        message_done;
  logic [23:0] resolved_length;
  logic [7:0]  resolved_type;
  logic [31:0] resolved_stream;
  logic [31:0] message_time;
  logic [16:0] bytes_taken;
  logic [16:0] bytes_left;

  modport source (
    input  clk, ready,
    output valid, status, message_done, resolved_length, resolved_type,
           resolved_stream, message_time, bytes_taken, bytes_left
  );
  modport sink (
    input  clk, valid, status, message_done, resolved_length, resolved_type,
           resolved_stream, message_time, bytes_taken, bytes_left,
    output ready
  );
endinterface

// ===== rtl/rcst_table.sv =====
module rcst_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  rcst_pkg::addr_t  rd_addr,
  input  rcst_pkg::wr_req_t wr,
  output logic             rd_valid,
  output rcst_pkg::entry_t rd_entry
);
  import rcst_pkg::*;

  entry_t                 mem [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] valid_r;
  logic                   rd_valid_r;
  entry_t                 rd_entry_r;
  logic                   hit;

  assign hit = wr.en && (wr.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // A write to the read address in the same cycle as the read is passed straight through.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_entry_r <= hit ? wr.data : mem[rd_addr];
      rd_valid_r <= hit | valid_r[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_entry = rd_entry_r;

endmodule

// ===== rtl/rcst_update.sv =====
module rcst_update (
  input  logic              fire,
  input  rcst_pkg::chunk_t  chunk,
  input  logic              rd_valid,
  input  rcst_pkg::entry_t  rd_entry,
  input  logic [31:0]       running_time,
  input  logic [16:0]       max_chunk,
  output rcst_pkg::wr_req_t wr,
  output logic              rt_we,
  output logic [31:0]       rt_nxt,
  output rcst_pkg::res_t    res
);
  import rcst_pkg::*;

  status_t     status;
  logic [23:0] count;
  hdr_t        cur;
  hdr_t        hdr;
  logic [24:0] sum;
  logic        consume;
  logic [31:0] delta;
  logic [31:0] rt_upd;
  logic [23:0] need;
  logic [16:0] min_a;
  logic [16:0] taken;
  logic [16:0] left;
  logic [24:0] new_sum;
  logic        fin;
  logic        first;

  always_comb begin
    if (chunk.chunk_stream < SID_FIRST) begin
      status = ST_RESERVED;
    end else if (chunk.chunk_stream >= SID_LIMIT) begin
      status = ST_RANGE;
    end else if (!rd_valid && chunk.header_format != FMT_FULL) begin
      status = ST_NO_HEADER;
    end else if (running_time == TIME_UNSET && chunk.header_format != FMT_FULL) begin
      status = ST_NO_TIME;
    end else begin
      status = ST_OK;
    end

    count = rd_valid ? rd_entry.count : '0;

    cur.fmt = chunk.header_format;
    cur.time_val = (chunk.header_format == FMT_NONE) ? rd_entry.hdr.time_val
                                                     : chunk.time_field;
    cur.ext_val = (chunk.header_format == FMT_NONE) ? rd_entry.hdr.ext_val
                                                    : chunk.extended_time;
    cur.len = (chunk.header_format == FMT_DELTA || chunk.header_format == FMT_NONE) ?
              rd_entry.hdr.len : chunk.message_length;
    cur.typ = (chunk.header_format == FMT_DELTA || chunk.header_format == FMT_NONE) ?
              rd_entry.hdr.typ : chunk.message_type;
    cur.strm = (chunk.header_format == FMT_FULL) ? chunk.message_stream
                                                 : rd_entry.hdr.strm;

    first = (count == '0);
    hdr = first ? cur : rd_entry.hdr;

    sum = {8'b0, chunk.payload_bytes} + {1'b0, count};
    consume = (chunk.payload_bytes >= max_chunk) || (sum >= {1'b0, hdr.len});

    delta = (hdr.time_val == TIME_ESCAPE) ? hdr.ext_val : {8'b0, hdr.time_val};
    rt_upd = (hdr.fmt == FMT_FULL) ? delta : running_time + delta;

    need = (hdr.len >= count) ? hdr.len - count : '0;
    min_a = (max_chunk < chunk.payload_bytes) ? max_chunk : chunk.payload_bytes;
    taken = ({7'b0, min_a} < need) ? min_a : need[16:0];
    left = chunk.payload_bytes - taken;
    new_sum = {1'b0, count} + {8'b0, taken};
    fin = (new_sum == {1'b0, hdr.len});

    wr.en = fire && (status == ST_OK);
    wr.addr = chunk.chunk_stream[SID_W-1:0];
    wr.data.hdr = hdr;
    wr.data.count = consume ? (fin ? '0 : new_sum[23:0]) : count;

    rt_we = wr.en && consume && first;
    rt_nxt = rt_upd;

    res = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.message_done = consume && fin;
      res.resolved_length = cur.len;
      res.resolved_type = cur.typ;
      res.resolved_stream = cur.strm;
      res.message_time = (consume && first) ? rt_upd : running_time;
      res.bytes_taken = consume ? taken : '0;
      res.bytes_left = consume ? left : '0;
    end
  end

endmodule

// ===== rtl/rtmp_chunk_stream_tracker_top.sv =====
// A chunk's result is registered as soon as the output register is free.
// Throughput: one chunk per cycle while results are accepted; the per-stream
// table is read on transfer, written back on fire, with same-stream bypass.
// Reset clears the stream valid bits, restores the maximum chunk size to 128
// and marks the running timestamp unset; the table contents are not cleared.
module rtmp_chunk_stream_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  rcst_chunk_if.sink  in_chunk,
  rcst_result_if.source out_result,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);
  import rcst_pkg::*;

  logic        s1_v_r;
  chunk_t      s1_chunk_r;
  logic        out_v_r;
  res_t        out_res_r;
  logic [16:0] max_chunk_r;
  logic [31:0] rt_r;

  logic        out_free;
  logic        fire;
  logic        in_acc;
  chunk_t      in_data;
  logic        rd_valid;
  entry_t      rd_entry;
  wr_req_t     wr;
  logic        rt_we;
  logic [31:0] rt_nxt;
  res_t        res;

  assign out_free = !out_v_r || out_result.ready;
  assign fire = s1_v_r && out_free;
  assign in_chunk.ready = !s1_v_r || out_free;
  assign in_acc = in_chunk.valid && in_chunk.ready;

  assign in_data.chunk_stream = in_chunk.chunk_stream;
  assign in_data.header_format = in_chunk.header_format;
  assign in_data.time_field = in_chunk.time_field;
  assign in_data.extended_time = in_chunk.extended_time;
  assign in_data.message_length = in_chunk.message_length;
  assign in_data.message_type = in_chunk.message_type;
  assign in_data.message_stream = in_chunk.message_stream;
  assign in_data.payload_bytes = in_chunk.payload_bytes;

  rcst_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (in_chunk.chunk_stream[SID_W-1:0]),
    .wr       (wr),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry)
  );

  rcst_update u_update (
    .fire         (fire),
    .chunk        (s1_chunk_r),
    .rd_valid     (rd_valid),
    .rd_entry     (rd_entry),
    .running_time (rt_r),
    .max_chunk    (max_chunk_r),
    .wr           (wr),
    .rt_we        (rt_we),
    .rt_nxt       (rt_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      out_v_r <= 1'b0;
      max_chunk_r <= MAX_CHUNK_RESET;
      rt_r <= TIME_UNSET;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (fire) begin
        s1_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_result.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        max_chunk_r <= cfg_wdata;
      end
      if (rt_we) begin
        rt_r <= rt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_chunk_r <= in_data;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_result.valid = out_v_r;
  assign out_result.status = out_res_r.status;
  assign out_result.message_done = out_res_r.message_done;
  assign out_result.resolved_length = out_res_r.resolved_length;
  assign out_result.resolved_type = out_res_r.resolved_type;
  assign out_result.resolved_stream = out_res_r.resolved_stream;
  assign out_result.message_time = out_res_r.message_time;
  assign out_result.bytes_taken = out_res_r.bytes_taken;
  assign out_result.bytes_left = out_res_r.bytes_left;

endmodule

// ===== rtl/rcst_checker.sv =====
module rcst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        message_done,
  input logic [31:0] message_time,
  input logic [16:0] bytes_taken,
  input logic [16:0] bytes_left
);
  import rcst_pkg::*;

  // An empty result register always leaves room for a new transfer.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while result register is empty");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ST_OK) |->
      (!message_done && message_time == '0 && bytes_taken == '0 && bytes_left == '0))
    else $error("error result carries nonzero fields");

  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && message_done) |-> status == ST_OK)
    else $error("message done reported with error status");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(message_time)))
    else $error("stalled result changed");

endmodule

bind rtmp_chunk_stream_tracker_top rcst_checker u_rcst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chunk.ready),
  .out_valid    (out_result.valid),
  .out_ready    (out_result.ready),
  .status       (out_result.status),
  .message_done (out_result.message_done),
  .message_time (out_result.message_time),
  .bytes_taken  (out_result.bytes_taken),
  .bytes_left   (out_result.bytes_left)
);

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rcst_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [16:0] cfg_wdata;

  rcst_chunk_if chunk_bus (.clk(clk));
  rcst_result_if result_bus (.clk(clk));

  rtmp_chunk_stream_tracker_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chunk   (chunk_bus),
    .out_result (result_bus),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the per-stream header table and the running timestamp.
  logic        stream_seen [NUM_STREAMS];
  hdr_t        stream_hdr [NUM_STREAMS];
  logic [23:0] stream_count [NUM_STREAMS];
  logic [31:0] stream_time;
  logic [16:0] max_chunk_now;

  res_t pending_results [$];
  res_t want_result;
  int   mismatches = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_cycles = 0;

  function automatic logic [31:0] min32(input logic [31:0] a, input logic [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic res_t decompress_chunk(input chunk_t c);
    res_t        r;
    hdr_t        h;
    int          sid;
    logic [31:0] cnt, len, need, delta, avail, taken;
    r = '0;
    if (c.chunk_stream < SID_FIRST) begin
      r.status = ST_RESERVED;
    end else if (c.chunk_stream >= SID_LIMIT) begin
      r.status = ST_RANGE;
    end else if (!stream_seen[c.chunk_stream] && c.header_format != FMT_FULL) begin
      r.status = ST_NO_HEADER;
    end else if (stream_time == TIME_UNSET && c.header_format != FMT_FULL) begin
      r.status = ST_NO_TIME;
    end
    if (r.status != ST_OK) return r;

    sid = c.chunk_stream;
    h.fmt = c.header_format;
    h.time_val = c.time_field;
    h.ext_val = c.extended_time;
    h.len = c.message_length;
    h.typ = c.message_type;
    h.strm = c.message_stream;
    if (c.header_format == FMT_NONE) begin
      h.time_val = stream_hdr[sid].time_val;
      h.ext_val = stream_hdr[sid].ext_val;
    end
    if (c.header_format == FMT_DELTA || c.header_format == FMT_NONE) begin
      h.len = stream_hdr[sid].len;
      h.typ = stream_hdr[sid].typ;
    end
    if (c.header_format != FMT_FULL) h.strm = stream_hdr[sid].strm;

    cnt = {8'd0, stream_count[sid]};
    if (cnt == 0) stream_hdr[sid] = h;
    stream_seen[sid] = 1'b1;
    len = {8'd0, stream_hdr[sid].len};
    avail = {15'd0, c.payload_bytes};

    // A short chunk that cannot finish the message is held back whole.
    if (avail >= {15'd0, max_chunk_now} || avail + cnt >= len) begin
      if (cnt == 0) begin
        delta = (stream_hdr[sid].time_val == TIME_ESCAPE) ? stream_hdr[sid].ext_val
                                                          : {8'd0, stream_hdr[sid].time_val};
        if (stream_hdr[sid].fmt == FMT_FULL) stream_time = delta;
        else stream_time = stream_time + delta;
      end
      need = (len >= cnt) ? len - cnt : 32'd0;
      taken = min32(min32({15'd0, max_chunk_now}, avail), need);
      r.bytes_taken = taken[16:0];
      r.bytes_left = 17'(avail - taken);
      cnt = cnt + taken;
      if (cnt == len) begin
        r.message_done = 1'b1;
        cnt = 0;
      end
      stream_count[sid] = cnt[23:0];
    end
    r.resolved_length = h.len;
    r.resolved_type = h.typ;
    r.resolved_stream = h.strm;
    r.message_time = stream_time;
    return r;
  endfunction

  task automatic send_chunk(input chunk_t c);
    while ($urandom_range(99) < idle_pct) begin
      chunk_bus.valid <= 1'b0;
      @(posedge clk);
    end
    chunk_bus.valid <= 1'b1;
    chunk_bus.chunk_stream <= c.chunk_stream;
    chunk_bus.header_format <= c.header_format;
    chunk_bus.time_field <= c.time_field;
    chunk_bus.extended_time <= c.extended_time;
    chunk_bus.message_length <= c.message_length;
    chunk_bus.message_type <= c.message_type;
    chunk_bus.message_stream <= c.message_stream;
    chunk_bus.payload_bytes <= c.payload_bytes;
    @(posedge clk);
    while (!chunk_bus.ready) @(posedge clk);
    pending_results.push_back(decompress_chunk(c));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_max_chunk(input logic [16:0] value);
    chunk_bus.valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_chunk_now = value;
  endtask

  function automatic chunk_t make_chunk(input logic [16:0] sid, input logic [1:0] fmt,
                                        input logic [23:0] tval, input logic [31:0] xval,
                                        input logic [23:0] len, input logic [7:0] typ,
                                        input logic [31:0] strm, input logic [16:0] avail);
    chunk_t c;
    c.chunk_stream = sid;
    c.header_format = fmt;
    c.time_field = tval;
    c.extended_time = xval;
    c.message_length = len;
    c.message_type = typ;
    c.message_stream = strm;
    c.payload_bytes = avail;
    return c;
  endfunction

  function automatic chunk_t random_chunk();
    chunk_t c;
    c.chunk_stream = $urandom_range(1) ? 17'($urandom_range(0, 65599))
                                       : 17'($urandom_range(0, 70));
    c.header_format = 2'($urandom_range(3));
    if ($urandom_range(9) == 0) c.time_field = TIME_ESCAPE;
    else if ($urandom_range(1)) c.time_field = 24'($urandom_range(0, 1000));
    else c.time_field = 24'($urandom);
    c.extended_time = $urandom;
    if ($urandom_range(49) == 0) begin
      c.time_field = TIME_ESCAPE;
      c.extended_time = TIME_UNSET;
    end
    c.message_length = 24'($urandom);
    c.message_type = 8'($urandom);
    c.message_stream = $urandom;
    c.payload_bytes = 17'($urandom_range(0, 65536));
    return c;
  endfunction

  // Chunks that follow the message structure of one stream, with random content.
  task automatic send_message_chunk();
    chunk_t      c;
    int          s;
    int          pick;
    logic [31:0] remaining, exact, avail;
    c = random_chunk();
    s = ($urandom_range(3) == 0) ? $urandom_range(2, NUM_STREAMS - 1) : $urandom_range(2, 9);
    c.chunk_stream = 17'(s);
    if (stream_count[s] != 0) begin
      c.header_format = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : FMT_NONE;
      remaining = {8'd0, stream_hdr[s].len} - {8'd0, stream_count[s]};
    end else begin
      if (!stream_seen[s] || $urandom_range(2) == 0) c.header_format = FMT_FULL;
      else c.header_format = 2'($urandom_range(1, 3));
      pick = $urandom_range(99);
      if (pick < 80) c.message_length = 24'($urandom_range(0, 400));
      else if (pick < 98) c.message_length = 24'($urandom_range(0, 5000));
      else c.message_length = 24'($urandom);
      if (c.header_format == FMT_DELTA || c.header_format == FMT_NONE) begin
        remaining = {8'd0, stream_hdr[s].len};
      end else begin
        remaining = {8'd0, c.message_length};
      end
    end
    exact = min32({15'd0, max_chunk_now}, remaining);
    pick = $urandom_range(99);
    if (pick < 60) avail = exact;
    else if (pick < 75) avail = exact + $urandom_range(0, 300);
    else if (pick < 85) avail = (exact > 0) ? $urandom_range(0, exact - 1) : 0;
    else avail = $urandom_range(0, 65536);
    c.payload_bytes = 17'(min32(avail, 32'd65536));
    send_chunk(c);
  endtask

  task automatic run_traffic(input int n);
    repeat (n) begin
      if ($urandom_range(9) == 0) send_chunk(random_chunk());
      else send_message_chunk();
    end
  endtask

  task automatic test_directed_cases();
    idle_pct = 0;
    stall_pct = 0;
    send_chunk(make_chunk(17'd0, FMT_FULL, 24'd0, 32'd0, 24'd10, 8'd1, 32'd1, 17'd10));
    send_chunk(make_chunk(17'd1, FMT_NONE, 24'd0, 32'd0, 24'd0, 8'd0, 32'd0, 17'd0));
    send_chunk(make_chunk(SID_LIMIT, FMT_FULL, 24'd1, 32'd1, 24'd1, 8'd1, 32'd1, 17'd1));
    send_chunk(make_chunk(17'd65599, FMT_FULL, 24'hffffff, 32'hffffffff, 24'hffffff,
                          8'hff, 32'hffffffff, 17'd65536));
    send_chunk(make_chunk(17'd2, FMT_NO_STREAM, 24'd5, 32'd0, 24'd4, 8'd2, 32'd0, 17'd4));
    // A short first chunk makes the entry valid but leaves the time unset.
    send_chunk(make_chunk(17'd5, FMT_FULL, 24'd100, 32'd0, 24'd1000, 8'd8, 32'd1, 17'd10));
    send_chunk(make_chunk(17'd5, FMT_NO_STREAM, 24'd1, 32'd0, 24'd1, 8'd1, 32'd0, 17'd1));
    send_chunk(make_chunk(17'd6, FMT_FULL, TIME_ESCAPE, 32'h12345678, 24'd0, 8'd20,
                          32'd3, 17'd0));
    send_chunk(make_chunk(17'd5, FMT_NONE, 24'd0, 32'd0, 24'd0, 8'd0, 32'd0, 17'd65536));
    send_chunk(make_chunk(17'd7, FMT_FULL, 24'd0, 32'hffffffff, 24'hffffff, 8'hff,
                          32'hffffffff, 17'd128));
    // A full header in the middle of a message keeps the saved length.
    send_chunk(make_chunk(17'd7, FMT_FULL, 24'd5, 32'd0, 24'd10, 8'd1, 32'd2, 17'd200));
    send_chunk(make_chunk(17'd6, FMT_NO_STREAM, 24'd50, 32'd0, 24'd3, 8'd9, 32'd0, 17'd3));
    send_chunk(make_chunk(17'd6, FMT_DELTA, TIME_ESCAPE, 32'd7, 24'd0, 8'd0, 32'd0, 17'd5));
    send_chunk(make_chunk(17'd6, FMT_NONE, 24'd0, 32'd0, 24'd0, 8'd0, 32'd0, 17'd3));
    send_chunk(make_chunk(17'd8, FMT_FULL, TIME_ESCAPE, TIME_UNSET, 24'd0, 8'd0, 32'd0,
                          17'd0));
    send_chunk(make_chunk(17'd6, FMT_NONE, 24'd0, 32'd0, 24'd0, 8'd0, 32'd0, 17'd3));
    send_chunk(make_chunk(17'd8, FMT_FULL, 24'hfffffe, 32'd0, 24'd0, 8'd0, 32'd0, 17'd0));
    send_chunk(make_chunk(17'd9, FMT_FULL, TIME_ESCAPE, 32'hfffffff0, 24'd0, 8'd0, 32'd0,
                          17'd0));
    send_chunk(make_chunk(17'd9, FMT_NO_STREAM, 24'd32, 32'd0, 24'd0, 8'd0, 32'd0, 17'd0));
    send_chunk(make_chunk(17'd63, FMT_FULL, 24'd1, 32'd0, 24'd2, 8'd0, 32'd0, 17'd1));
    send_chunk(make_chunk(17'd63, FMT_NONE, 24'd0, 32'd0, 24'd0, 8'd0, 32'd0, 17'd5));
    send_chunk(make_chunk(17'd2, FMT_FULL, 24'd0, 32'd0, 24'd128, 8'd0, 32'd0, 17'd0));
  endtask

  task automatic test_max_chunk();
    int sizes [10] = '{128, 1, 65536, 7, 0, 131071, 300, 2, 1000, 128};
    int items [10] = '{150, 150, 150, 150, 40, 60, 150, 150, 150, 50};
    int idles [4] = '{0, 57, 0, 6};
    int stalls [4] = '{0, 0, 57, 6};
    for (int k = 0; k < 10; k++) begin
      set_max_chunk(17'(sizes[k]));
      idle_pct = idles[k % 4];
      stall_pct = stalls[k % 4];
      run_traffic(items[k]);
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    run_traffic(60);
    chunk_bus.valid <= 1'b0;
    wait_drained();
    run_traffic(20);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      result_bus.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s: expected %h, actual %h", field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result transfer with none pending: status %h time %h",
                   result_bus.status, result_bus.message_time);
        end
      end else begin
        want_result = pending_results.pop_front();
        check_field("status", 32'(want_result.status), 32'(result_bus.status));
        check_field("message_done", 32'(want_result.message_done),
                    32'(result_bus.message_done));
        check_field("resolved_length", 32'(want_result.resolved_length),
                    32'(result_bus.resolved_length));
        check_field("resolved_type", 32'(want_result.resolved_type),
                    32'(result_bus.resolved_type));
        check_field("resolved_stream", want_result.resolved_stream,
                    result_bus.resolved_stream);
        check_field("message_time", want_result.message_time, result_bus.message_time);
        check_field("bytes_taken", 32'(want_result.bytes_taken),
                    32'(result_bus.bytes_taken));
        check_field("bytes_left", 32'(want_result.bytes_left), 32'(result_bus.bytes_left));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    chunk_bus.valid = 1'b0;
    chunk_bus.chunk_stream = '0;
    chunk_bus.header_format = '0;
    chunk_bus.time_field = '0;
    chunk_bus.extended_time = '0;
    chunk_bus.message_length = '0;
    chunk_bus.message_type = '0;
    chunk_bus.message_stream = '0;
    chunk_bus.payload_bytes = '0;
    result_bus.ready = 1'b0;
    for (int k = 0; k < NUM_STREAMS; k++) begin
      stream_seen[k] = 1'b0;
      stream_hdr[k] = '0;
      stream_count[k] = '0;
    end
    stream_time = TIME_UNSET;
    max_chunk_now = MAX_CHUNK_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_max_chunk();
    test_backpressure();

    chunk_bus.valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rcst_pkg.sv
rtl/rcst_ifs.sv
rtl/rcst_table.sv
rtl/rcst_update.sv
rtl/rtmp_chunk_stream_tracker_top.sv
rtl/rcst_checker.sv
bench/tb_top.sv
